@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the converter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define YRGB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define YRGB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/yuyv2rgb_pkg.sv @@
// Types, constants and helpers for the YUYV to RGB888 converter
package yuyv2rgb_pkg;

    localparam int DEF_FRAC_BITS = 16;

    // Coefficients in millionths, turned into fixed point at elaboration
    localparam longint unsigned KR_MICRO  = 64'd1370705;
    localparam longint unsigned KGV_MICRO = 64'd698001;
    localparam longint unsigned KGU_MICRO = 64'd337633;
    localparam longint unsigned KB_MICRO  = 64'd1732446;
    localparam longint unsigned MICRO_ONE = 64'd1000000;
    localparam longint unsigned MICRO_HALF = 64'd500000;

    // Configuration register map
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_ORDER_ADDR = 3'd0;

    localparam logic [7:0] DIM_NUM = 8'd220;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       last_word;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] first_byte_a;
        logic [7:0] first_byte_b;
        logic [7:0] first_byte_c;
        logic [7:0] second_byte_a;
        logic [7:0] second_byte_b;
        logic [7:0] second_byte_c;
        logic       frame_end;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // floor(x * 220 / 256)
    function automatic logic [7:0] dim_byte(input logic [7:0] x);
        logic [15:0] prod;
        prod = 16'(x) * 16'(DIM_NUM);
        return prod[15:8];
    endfunction

endpackage

@@ hw/rtl/yuyv2rgb_chroma.sv @@
// Shared chroma stage: centers U/V and forms the four coefficient products
module yuyv2rgb_chroma
    import yuyv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int P_W       = FRAC_BITS + 11
) (
    input  logic                  aclk,
    input  logic                  load,
    input  in_beat_t              beat_in,
    output logic signed [P_W-1:0] prod_r_reg,
    output logic signed [P_W-1:0] prod_gv_reg,
    output logic signed [P_W-1:0] prod_gu_reg,
    output logic signed [P_W-1:0] prod_b_reg,
    output logic [7:0]            luma0_reg,
    output logic [7:0]            luma1_reg,
    output logic                  last_reg
);

    localparam longint unsigned KR  = ((KR_MICRO  << FRAC_BITS) + MICRO_HALF) / MICRO_ONE;
    localparam longint unsigned KGV = ((KGV_MICRO << FRAC_BITS) + MICRO_HALF) / MICRO_ONE;
    localparam longint unsigned KGU = ((KGU_MICRO << FRAC_BITS) + MICRO_HALF) / MICRO_ONE;
    localparam longint unsigned KB  = ((KB_MICRO  << FRAC_BITS) + MICRO_HALF) / MICRO_ONE;

    localparam logic signed [P_W-1:0] KR_S  = P_W'(KR);
    localparam logic signed [P_W-1:0] KGV_S = P_W'(KGV);
    localparam logic signed [P_W-1:0] KGU_S = P_W'(KGU);
    localparam logic signed [P_W-1:0] KB_S  = P_W'(KB);

    logic signed [8:0]     du;
    logic signed [8:0]     dv;
    logic signed [P_W-1:0] prod_r_next;
    logic signed [P_W-1:0] prod_gv_next;
    logic signed [P_W-1:0] prod_gu_next;
    logic signed [P_W-1:0] prod_b_next;

    // c - 128 as a 9-bit signed value: flip the top bit
    assign du = $signed({~beat_in.chroma_blue[7], ~beat_in.chroma_blue[7],
                         beat_in.chroma_blue[6:0]});
    assign dv = $signed({~beat_in.chroma_red[7], ~beat_in.chroma_red[7],
                         beat_in.chroma_red[6:0]});

    assign prod_r_next  = KR_S  * P_W'(dv);
    assign prod_gv_next = KGV_S * P_W'(dv);
    assign prod_gu_next = KGU_S * P_W'(du);
    assign prod_b_next  = KB_S  * P_W'(du);

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_r_reg  <= prod_r_next;
            prod_gv_reg <= prod_gv_next;
            prod_gu_reg <= prod_gu_next;
            prod_b_reg  <= prod_b_next;
            luma0_reg   <= beat_in.luma_first;
            luma1_reg   <= beat_in.luma_second;
            last_reg    <= beat_in.last_word;
        end
    end

endmodule

@@ hw/rtl/yuyv2rgb_lane.sv @@
// One pixel lane: adds luma to the chroma terms and clamps each channel to a byte
module yuyv2rgb_lane
    import yuyv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int P_W       = FRAC_BITS + 11
) (
    input  logic                  aclk,
    input  logic                  load,
    input  logic [7:0]            luma,
    input  logic signed [P_W-1:0] prod_r,
    input  logic signed [P_W-1:0] prod_gv,
    input  logic signed [P_W-1:0] prod_gu,
    input  logic signed [P_W-1:0] prod_b,
    output rgb_t                  pix_reg
);

    logic signed [P_W-1:0] base;
    logic signed [P_W-1:0] acc_r;
    logic signed [P_W-1:0] acc_g;
    logic signed [P_W-1:0] acc_b;
    rgb_t                  pix_next;

    // Negative sums truncate to zero or below, so the sign alone clamps low
    function automatic logic [7:0] clamp_byte(input logic signed [P_W-1:0] acc);
        logic [7:0] res;
        if (acc[P_W-1]) begin
            res = 8'd0;
        end else if (|acc[P_W-2:FRAC_BITS+8]) begin
            res = 8'd255;
        end else begin
            res = acc[FRAC_BITS+7:FRAC_BITS];
        end
        return res;
    endfunction

    assign base  = $signed({{(P_W-8-FRAC_BITS){1'b0}}, luma, {FRAC_BITS{1'b0}}});
    assign acc_r = base + prod_r;
    assign acc_g = base - prod_gv - prod_gu;
    assign acc_b = base + prod_b;

    assign pix_next.r = clamp_byte(acc_r);
    assign pix_next.g = clamp_byte(acc_g);
    assign pix_next.b = clamp_byte(acc_b);

    always_ff @(posedge aclk) begin
        if (load) begin
            pix_reg <= pix_next;
        end
    end

endmodule

@@ hw/rtl/yuyv2rgb_merge.sv @@
// Merge stage: dims both pixels, applies byte order and holds the output beat
module yuyv2rgb_merge
    import yuyv2rgb_pkg::*;
(
    input  logic      aclk,
    input  logic      load,
    input  logic      order_bgr,
    input  rgb_t      pix0,
    input  rgb_t      pix1,
    input  logic      last,
    output out_beat_t beat_reg
);

    out_beat_t beat_next;
    rgb_t      dim0;
    rgb_t      dim1;

    always_comb begin
        dim0.r = dim_byte(pix0.r);
        dim0.g = dim_byte(pix0.g);
        dim0.b = dim_byte(pix0.b);
        dim1.r = dim_byte(pix1.r);
        dim1.g = dim_byte(pix1.g);
        dim1.b = dim_byte(pix1.b);

        beat_next.first_byte_a  = order_bgr ? dim0.b : dim0.r;
        beat_next.first_byte_b  = dim0.g;
        beat_next.first_byte_c  = order_bgr ? dim0.r : dim0.b;
        beat_next.second_byte_a = order_bgr ? dim1.b : dim1.r;
        beat_next.second_byte_b = dim1.g;
        beat_next.second_byte_c = order_bgr ? dim1.r : dim1.b;
        beat_next.frame_end     = last;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg <= beat_next;
        end
    end

endmodule

@@ hw/rtl/yuyv_to_rgb888_converter.sv @@
// YUYV 4:2:2 to RGB888 converter, top level with pipeline control and APB register
// Takes one YUYV word per beat and returns two dimmed 24-bit pixels per beat. The
// pipeline has three register stages (chroma products, two pixel lanes, output
// merge), which a beat passes through in order from s_ to m_, and one beat
// is accepted every cycle while m_ready is high. A stall on m_ready holds the
// stages; empty stages still fill, so up to three beats are in flight. s_ready
// follows m_ready combinationally through the stage occupancy. The byte order
// register (offset 0x0, bit 0: 0 = R,G,B, 1 = B,G,R) is applied at the merge
// stage and should be changed only while the pipeline is empty.
`include "assert_macros.svh"

module yuyv_to_rgb888_converter
    import yuyv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input beats
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    // output beats
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int P_W = FRAC_BITS + 11;

    logic v1_reg;
    logic v1_next;
    logic v2_reg;
    logic v2_next;
    logic v3_reg;
    logic v3_next;
    logic ready1;
    logic ready2;
    logic ready3;
    logic order_bgr_reg;
    logic order_bgr_next;
    logic last2_reg;

    logic signed [P_W-1:0] prod_r;
    logic signed [P_W-1:0] prod_gv;
    logic signed [P_W-1:0] prod_gu;
    logic signed [P_W-1:0] prod_b;
    logic [7:0]            luma0;
    logic [7:0]            luma1;
    logic                  last1;
    rgb_t                  pix0;
    rgb_t                  pix1;

    // Stage enables: a stage loads when it is empty or its content moves on
    assign ready3  = !v3_reg || m_ready;
    assign ready2  = !v2_reg || ready3;
    assign ready1  = !v1_reg || ready2;
    assign s_ready = ready1;

    assign v1_next = ready1 ? s_valid : v1_reg;
    assign v2_next = ready2 ? v1_reg  : v2_reg;
    assign v3_next = ready3 ? v2_reg  : v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign m_valid = v3_reg;

    // Configuration register
    assign pready = 1'b1;
    assign order_bgr_next = (psel && penable && pwrite && paddr == REG_ORDER_ADDR)
                          ? pwdata[0] : order_bgr_reg;
    assign prdata = (paddr == REG_ORDER_ADDR) ? {31'd0, order_bgr_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_bgr_reg <= 1'b0;
        end else begin
            order_bgr_reg <= order_bgr_next;
        end
    end

    yuyv2rgb_chroma #(
        .FRAC_BITS (FRAC_BITS),
        .P_W       (P_W)
    ) u_chroma (
        .aclk        (aclk),
        .load        (ready1),
        .beat_in     (s_data),
        .prod_r_reg  (prod_r),
        .prod_gv_reg (prod_gv),
        .prod_gu_reg (prod_gu),
        .prod_b_reg  (prod_b),
        .luma0_reg   (luma0),
        .luma1_reg   (luma1),
        .last_reg    (last1)
    );

    yuyv2rgb_lane #(
        .FRAC_BITS (FRAC_BITS),
        .P_W       (P_W)
    ) u_lane0 (
        .aclk    (aclk),
        .load    (ready2),
        .luma    (luma0),
        .prod_r  (prod_r),
        .prod_gv (prod_gv),
        .prod_gu (prod_gu),
        .prod_b  (prod_b),
        .pix_reg (pix0)
    );

    yuyv2rgb_lane #(
        .FRAC_BITS (FRAC_BITS),
        .P_W       (P_W)
    ) u_lane1 (
        .aclk    (aclk),
        .load    (ready2),
        .luma    (luma1),
        .prod_r  (prod_r),
        .prod_gv (prod_gv),
        .prod_gu (prod_gu),
        .prod_b  (prod_b),
        .pix_reg (pix1)
    );

    always_ff @(posedge aclk) begin
        if (ready2) begin
            last2_reg <= last1;
        end
    end

    yuyv2rgb_merge u_merge (
        .aclk      (aclk),
        .load      (ready3),
        .order_bgr (order_bgr_reg),
        .pix0      (pix0),
        .pix1      (pix1),
        .last      (last2_reg),
        .beat_reg  (m_data)
    );

    `YRGB_ASSERT_NXT(a_accept_fills_s1, aclk, aresetn, s_valid && s_ready, v1_reg, "accepted beat did not reach stage 1")
    `YRGB_ASSERT_NXT(a_s1_holds, aclk, aresetn, v1_reg && !ready2, v1_reg, "stage 1 beat lost during stall")
    `YRGB_ASSERT_NXT(a_s2_holds, aclk, aresetn, v2_reg && !ready3, v2_reg && $stable(last2_reg), "stage 2 beat changed during stall")

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the YUYV 4:2:2 to RGB888 pixel-pair converter
module tb
    import yuyv2rgb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_WORDS = 458;
    // index 4 of the register map; nothing is decoded there
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_ADDR = 3'd4;

    // chroma coefficients, rounded half up to FRAC fraction bits
    localparam longint K_RV = longint'(((64'd1370705 << FRAC) + 64'd500000) / 64'd1000000);
    localparam longint K_GV = longint'(((64'd698001 << FRAC) + 64'd500000) / 64'd1000000);
    localparam longint K_GU = longint'(((64'd337633 << FRAC) + 64'd500000) / 64'd1000000);
    localparam longint K_BU = longint'(((64'd1732446 << FRAC) + 64'd500000) / 64'd1000000);
    localparam longint FX_ONE = longint'(1) << FRAC;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    in_beat_t  yuyv_q[$];
    out_beat_t pixel_pair_q[$];
    bit        bgr_order = 1'b0;
    bit        hold_src = 1'b0;
    int        src_idle_pct = 0;
    int        snk_stall_pct = 0;
    int        mismatch_cnt = 0;
    int        quiet_cycles = 0;

    yuyv_to_rgb888_converter #(.FRAC_BITS(FRAC)) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // truncate toward zero, clamp to a byte, then dim by 220/256
    function automatic logic [7:0] dim_channel(input longint acc);
        longint x;
        x = acc / FX_ONE;
        if (x < 0) x = 0;
        if (x > 255) x = 255;
        return 8'((x * 220) >>> 8);
    endfunction

    function automatic rgb_t yuv_pixel(input logic [7:0] y, input longint du, input longint dv);
        longint base;
        rgb_t p;
        base = longint'(y) * FX_ONE;
        p.r = dim_channel(base + K_RV * dv);
        p.g = dim_channel(base - K_GV * dv - K_GU * du);
        p.b = dim_channel(base + K_BU * du);
        return p;
    endfunction

    function automatic out_beat_t convert_word(input in_beat_t w, input bit bgr);
        longint du;
        longint dv;
        rgb_t p0;
        rgb_t p1;
        out_beat_t o;
        du = longint'(w.chroma_blue) - 128;
        dv = longint'(w.chroma_red) - 128;
        p0 = yuv_pixel(w.luma_first, du, dv);
        p1 = yuv_pixel(w.luma_second, du, dv);
        if (bgr) begin
            o.first_byte_a = p0.b;  o.first_byte_c = p0.r;
            o.second_byte_a = p1.b; o.second_byte_c = p1.r;
        end else begin
            o.first_byte_a = p0.r;  o.first_byte_c = p0.b;
            o.second_byte_a = p1.r; o.second_byte_c = p1.b;
        end
        o.first_byte_b = p0.g;
        o.second_byte_b = p1.g;
        o.frame_end = w.last_word;
        return o;
    endfunction

    // input driver: a new beat only after the previous one was taken
    always @(negedge aclk) begin
        logic      nxt_valid;
        in_beat_t  nxt_data;
        nxt_valid = s_valid;
        nxt_data = s_data;
        if (!s_valid) begin
            if (yuyv_q.size() > 0 && !hold_src && $urandom_range(99) >= src_idle_pct) begin
                nxt_valid = 1'b1;
                nxt_data = yuyv_q[0];
            end
        end
        s_valid <= nxt_valid;
        s_data <= nxt_data;
        m_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // acceptance, prediction and output check
    always @(posedge aclk) begin
        out_beat_t want;
        in_beat_t  taken;
        if (s_valid && s_ready) begin
            taken = yuyv_q.pop_front();
            pixel_pair_q = {pixel_pair_q, convert_word(taken, bgr_order)};
            s_valid <= 1'b0;
        end
        if (m_valid && m_ready) begin
            if (pixel_pair_q.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("ERROR: unexpected output beat %h", m_data);
                mismatch_cnt++;
            end else begin
                want = pixel_pair_q.pop_front();
                if (m_data.first_byte_a !== want.first_byte_a ||
                    m_data.first_byte_b !== want.first_byte_b ||
                    m_data.first_byte_c !== want.first_byte_c ||
                    m_data.second_byte_a !== want.second_byte_a ||
                    m_data.second_byte_b !== want.second_byte_b ||
                    m_data.second_byte_c !== want.second_byte_c ||
                    m_data.frame_end !== want.frame_end) begin
                    if (mismatch_cnt < 10)
                        $display("ERROR: pixel pair exp %h %h %h | %h %h %h end %b, got %h %h %h | %h %h %h end %b",
                                 want.first_byte_a, want.first_byte_b, want.first_byte_c,
                                 want.second_byte_a, want.second_byte_b, want.second_byte_c,
                                 want.frame_end,
                                 m_data.first_byte_a, m_data.first_byte_b, m_data.first_byte_c,
                                 m_data.second_byte_a, m_data.second_byte_b, m_data.second_byte_c,
                                 m_data.frame_end);
                    mismatch_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] val);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == REG_ORDER_ADDR) bgr_order = val[0];
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic queue_word(input logic [7:0] y0, input logic [7:0] u, input logic [7:0] y1,
                              input logic [7:0] v, input logic last);
        in_beat_t w;
        w.luma_first = y0;
        w.chroma_blue = u;
        w.luma_second = y1;
        w.chroma_red = v;
        w.last_word = last;
        yuyv_q = {yuyv_q, w};
    endtask

    // a quarter of the bytes come from the corners and the chroma midpoint
    function automatic logic [7:0] pick_byte();
        logic [7:0] corners[7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
        if ($urandom_range(3) == 0) return corners[$urandom_range(6)];
        return 8'($urandom);
    endfunction

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            queue_word(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                       $urandom_range(7) == 0);
    endtask

    // wait on the falling edge so the posedge bookkeeping has settled
    task automatic wait_drained();
        @(negedge aclk);
        while (yuyv_q.size() > 0 || pixel_pair_q.size() > 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic run_phase(input int n, input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        @(posedge aclk);
        push_random(n / 2);
        @(negedge aclk);
        while (yuyv_q.size() > 0) @(negedge aclk);
        // let the pipeline run dry before the second half
        hold_src = 1'b1;
        while (pixel_pair_q.size() > 0) @(negedge aclk);
        @(posedge aclk);
        hold_src = 1'b0;
        push_random(n - n / 2);
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        cfg_write(REG_ORDER_ADDR, 32'd0);
        @(posedge aclk);
        queue_word(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        queue_word(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        queue_word(8'd128, 8'd128, 8'd128, 8'd128, 1'b0);
        queue_word(8'd0, 8'd128, 8'd255, 8'd255, 1'b0);
        queue_word(8'd255, 8'd128, 8'd0, 8'd0, 1'b0);
        queue_word(8'd0, 8'd255, 8'd255, 8'd128, 1'b0);
        queue_word(8'd255, 8'd0, 8'd0, 8'd128, 1'b1);
        queue_word(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
        queue_word(8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
        // sums just below zero truncate to zero rather than to -1
        queue_word(8'd1, 8'd127, 8'd0, 8'd127, 1'b0);
        queue_word(8'd1, 8'd129, 8'd2, 8'd129, 1'b0);
        queue_word(8'd254, 8'd129, 8'd253, 8'd129, 1'b0);
        queue_word(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b1);
        queue_word(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b0);
        queue_word(8'd16, 8'd128, 8'd235, 8'd128, 1'b0);
        queue_word(8'd200, 8'd60, 8'd40, 8'd220, 1'b0);
        queue_word(8'd60, 8'd200, 8'd180, 8'd30, 1'b1);
        queue_word(8'd81, 8'd90, 8'd82, 8'd240, 1'b0);
        queue_word(8'd145, 8'd54, 8'd41, 8'd34, 1'b0);
        queue_word(8'd128, 8'd0, 8'd128, 8'd255, 1'b1);
        wait_drained();

        cfg_write(REG_ORDER_ADDR, 32'd1);
        run_phase(PHASE_WORDS, 0, 0);

        // no register at index 4, and only bit 0 of the order register counts
        cfg_write(REG_SPARE_ADDR, 32'hFFFF_FFFF);
        cfg_write(REG_ORDER_ADDR, 32'hFFFF_FFFE);
        run_phase(PHASE_WORDS, 88, 0);

        cfg_write(REG_ORDER_ADDR, 32'h8000_0001);
        run_phase(PHASE_WORDS, 0, 88);

        cfg_write(REG_ORDER_ADDR, 32'd0);
        run_phase(PHASE_WORDS, 22, 22);

        repeat (10) @(posedge aclk);
        mismatch_cnt += pixel_pair_q.size();
        if (mismatch_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/yuyv2rgb_pkg.sv
hw/rtl/yuyv2rgb_chroma.sv
hw/rtl/yuyv2rgb_lane.sv
hw/rtl/yuyv2rgb_merge.sv
hw/rtl/yuyv_to_rgb888_converter.sv
dv/tb.sv
